/* hdl/cdq_pkg.sv */
// Shared types and constants for the circular deque core.
// Used by cdq_store, cdq_ctrl and circular_deque_core; no dependencies.
package cdq_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);

  localparam logic [CntW-1:0] CapReset = CntW'(Depth);

  // Operation codes carried on mode_i
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_REAR  = 3'd5,
    MODE_NOP_A      = 3'd6,
    MODE_NOP_B      = 3'd7
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  // Access from the controller to the element store
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [IdxW-1:0]  raddr;
  } store_req_t;

endpackage

/* hdl/cdq_store.sv */
// Element store of the deque: one write port, one registered read port.
// Depends on cdq_pkg for sizes and the request struct.
module cdq_store import cdq_pkg::*; (
  input  logic             clk_i,
  input  store_req_t       req_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/cdq_ctrl.sv */
// Deque controller: front/rear indices, element count, capacity register,
// store requests and the registered result fields. Depends on cdq_pkg.
module cdq_ctrl import cdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [2:0]       mode_i,
  input  logic [DataW-1:0] data_in_i,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_data_i,
  output store_req_t       store_req_o,
  output logic             done_o,
  output logic             rd_sel_o,
  output logic [1:0]       status_o,
  output logic [CntW-1:0]  count_now_o,
  output logic             is_empty_o,
  output logic             is_full_o
);

  logic [IdxW-1:0] front_q, front_d, rear_q, rear_d;
  logic [CntW-1:0] cnt_q, cnt_d, cap_q, cap_d;
  logic            done_q, rd_sel_q, rd_sel_d;
  status_e         status_q, status_d;
  logic            full, empty;
  logic [IdxW-1:0] front_dn, front_up, rear_dn, rear_up;
  logic [CntW-1:0] cfg_val;
  mode_e           mode;

  assign mode  = mode_e'(mode_i);
  assign full  = (cnt_q >= cap_q);
  assign empty = (cnt_q == '0);

  // wrap-around neighbors within the capacity in use
  assign front_dn = (front_q == '0) ? IdxW'(cap_q - CntW'(1)) : front_q - IdxW'(1);
  assign rear_dn  = (rear_q == '0)  ? IdxW'(cap_q - CntW'(1)) : rear_q - IdxW'(1);
  assign front_up = ((CntW'(front_q) + CntW'(1)) >= cap_q) ? '0 : front_q + IdxW'(1);
  assign rear_up  = ((CntW'(rear_q) + CntW'(1)) >= cap_q)  ? '0 : rear_q + IdxW'(1);

  // capacity write, clamped to 1..Depth, only when empty
  always_comb begin
    cfg_val = CntW'(cfg_data_i);
    if (cfg_val == '0) begin
      cfg_val = CntW'(1);
    end else if (cfg_val > CntW'(Depth)) begin
      cfg_val = CntW'(Depth);
    end
    cap_d = cap_q;
    if (cfg_we_i && empty) begin
      cap_d = cfg_val;
    end
  end

  // operation decode and next state
  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    cnt_d       = cnt_q;
    status_d    = ST_OK;
    rd_sel_d    = 1'b0;
    store_req_o = '{we: 1'b0, waddr: front_q, wdata: data_in_i, re: 1'b0, raddr: front_q};
    if (accept_i) begin
      case (mode)
        MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            if (empty) begin
              front_d = '0;
              rear_d  = '0;
              store_req_o.waddr = '0;
            end else if (mode == MODE_PUSH_FRONT) begin
              front_d = front_dn;
              store_req_o.waddr = front_dn;
            end else begin
              rear_d = rear_up;
              store_req_o.waddr = rear_up;
            end
            store_req_o.we = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        MODE_POP_FRONT, MODE_POP_REAR, MODE_PEEK_FRONT, MODE_PEEK_REAR: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            rd_sel_d       = 1'b1;
            store_req_o.re = 1'b1;
            if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT) begin
              store_req_o.raddr = front_q;
            end else begin
              store_req_o.raddr = rear_q;
            end
            if (mode == MODE_POP_FRONT || mode == MODE_POP_REAR) begin
              if (cnt_q == CntW'(1)) begin
                front_d = '0;
                rear_d  = '0;
              end else if (mode == MODE_POP_FRONT) begin
                front_d = front_up;
              end else begin
                rear_d = rear_dn;
              end
              cnt_d = cnt_q - CntW'(1);
            end
          end
        end
        default: begin
          // unused codes leave the state alone
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      cnt_q   <= '0;
      cap_q   <= CapReset;
      done_q  <= 1'b0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
      done_q  <= accept_i;
    end
  end

  // result fields, captured with each request
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      status_q <= status_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  assign done_o      = done_q;
  assign rd_sel_o    = rd_sel_q;
  assign status_o    = status_q;
  assign count_now_o = cnt_q;
  assign is_empty_o  = (cnt_q == '0);
  assign is_full_o   = full;

endmodule

/* hdl/circular_deque_core.sv */
// Circular deque core: top level joining the controller and element store.
// The result strobe done_o is registered and rises in the cycle after a request is taken.
// Throughput: one request per cycle; the store read and write both complete
// at the accepting edge, so busy stays low and done_o cannot be held off.
// Reset: indices and count clear, capacity returns to 16; store is not cleared.
// Depends on cdq_pkg, cdq_ctrl and cdq_store.
module circular_deque_core import cdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       mode_i,
  input  logic [DataW-1:0] data_in_i,
  output logic             done_o,
  output logic [DataW-1:0] data_out_o,
  output logic [1:0]       status_o,
  output logic [CntW-1:0]  count_now_o,
  output logic             is_empty_o,
  output logic             is_full_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [4:0]       cfg_data_i
);

  store_req_t       store_req;
  logic [DataW-1:0] rdata;
  logic             rd_sel;
  logic             accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .data_in_i   (data_in_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .store_req_o (store_req),
    .done_o      (done_o),
    .rd_sel_o    (rd_sel),
    .status_o    (status_o),
    .count_now_o (count_now_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o)
  );

  cdq_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (rdata)
  );

  // data is zero for pushes, refusals and unused codes
  assign data_out_o = rd_sel ? rdata : '0;

endmodule
